@@ rtl/bswd_pkg.sv @@
// Shared types and constants for the bubble sort block with selectable direction.
// No dependencies; used by bubble_sort_with_direction.
`default_nettype none

package bswd_pkg;

   localparam int DATA_W            = 32;
   localparam int MAX_ELEMENTS_DEF  = 64;
   localparam int CSR_ADDR_W        = 3;

   // register index of sort_direction
   localparam logic REG_SORT_DIRECTION = 1'b0;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS_START,
      ST_PASS_FIRST,
      ST_PASS_RUN,
      ST_PASS_END,
      ST_EMIT_READ,
      ST_EMIT_SHOW
   } state_type;

endpackage

`default_nettype wire

@@ rtl/bswd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bswd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/bubble_sort_with_direction.sv @@
// Top level: loads a set of signed words, bubble-sorts them in place, streams them out.
// Depends on bswd_pkg and bswd_ram.
//
//   channel   direction   handshake              payload
//   req       in          req_tvalid/req_tready  req_tdata = value, req_tlast = is_last
//   rsp       out         rsp_tvalid/rsp_tready  rsp_tdata = sorted_value, rsp_tlast = is_last_res
//   csr       in          APB, pready high       addr 0: sort_direction (bit 0)
//
// Loading writes each accepted beat straight into the element RAM. A set of N elements then
// sorts with one comparator over the element RAM in at most N passes, and each output beat
// is a RAM read followed by a show.
// req_tready is low after the completing beat until the last result beat is taken.
// Reset is synchronous and clears control state and sort_direction; the RAM is not cleared.
`default_nettype none

module bubble_sort_with_direction #(
   parameter int MAX_ELEMENTS = bswd_pkg::MAX_ELEMENTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: [31:0] value
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bswd_pkg::DATA_W-1:0]       req_tdata,
   input  wire logic                              req_tlast,
   // rsp_tdata: [31:0] sorted_value
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [bswd_pkg::DATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bswd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic      [31:0]                       csr_prdata,
   output logic                                   csr_pready
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int DW = bswd_pkg::DATA_W;

   bswd_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic signed [DW-1:0] held_ff, held_in;
   logic                 swapped_ff, swapped_in;
   logic                 dir_ff, dir_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [DW-1:0]        wr_data;
   logic [AW-1:0]        rd_addr;
   logic [DW-1:0]        rd_data;

   logic                 req_beat;
   logic                 rsp_beat;
   logic                 set_done;
   logic [AW-1:0]        last_idx;
   logic signed [DW-1:0] cand;
   logic                 out_of_order;
   logic                 csr_write;
   logic                 csr_hit;

   bswd_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // configuration
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == bswd_pkg::REG_SORT_DIRECTION);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign dir_in     = (csr_write && csr_hit) ? csr_pwdata[0] : dir_ff;
   assign csr_prdata = csr_hit ? {31'b0, dir_ff} : 32'b0;

   assign req_tready = (state_ff == bswd_pkg::ST_LOAD);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == bswd_pkg::ST_EMIT_SHOW);
   assign rsp_beat   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = rd_data;

   assign last_idx     = AW'(count_ff - 1'b1);
   assign rsp_tlast    = (idx_ff == last_idx);
   assign set_done     = req_tlast || (count_ff == CW'(MAX_ELEMENTS - 1));
   assign cand         = $signed(rd_data);
   assign out_of_order = dir_ff ? (cand > held_ff) : (held_ff > cand);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bswd_pkg::ST_LOAD: begin
            if (req_beat && set_done) begin
               state_in = (count_ff == '0) ? bswd_pkg::ST_EMIT_READ
                                           : bswd_pkg::ST_PASS_START;
            end
         end
         bswd_pkg::ST_PASS_START: state_in = bswd_pkg::ST_PASS_FIRST;
         bswd_pkg::ST_PASS_FIRST: state_in = bswd_pkg::ST_PASS_RUN;
         bswd_pkg::ST_PASS_RUN: begin
            if (idx_ff == last_idx) begin
               state_in = bswd_pkg::ST_PASS_END;
            end
         end
         bswd_pkg::ST_PASS_END: begin
            state_in = swapped_ff ? bswd_pkg::ST_PASS_START : bswd_pkg::ST_EMIT_READ;
         end
         bswd_pkg::ST_EMIT_READ: state_in = bswd_pkg::ST_EMIT_SHOW;
         bswd_pkg::ST_EMIT_SHOW: begin
            if (rsp_beat) begin
               state_in = rsp_tlast ? bswd_pkg::ST_LOAD : bswd_pkg::ST_EMIT_READ;
            end
         end
         default: state_in = bswd_pkg::ST_LOAD;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      held_in    = held_ff;
      swapped_in = swapped_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = held_ff;
      rd_addr    = idx_ff;
      unique case (state_ff)
         bswd_pkg::ST_LOAD: begin
            if (req_beat) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[AW-1:0];
               wr_data  = req_tdata;
               count_in = CW'(count_ff + 1'b1);
               idx_in   = '0;
            end
         end
         bswd_pkg::ST_PASS_START: begin
            rd_addr    = '0;
            swapped_in = 1'b0;
         end
         bswd_pkg::ST_PASS_FIRST: begin
            held_in = cand;
            rd_addr = AW'(1);
            idx_in  = AW'(1);
         end
         bswd_pkg::ST_PASS_RUN: begin
            // keep the element that travels on, drop the other behind it
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff - 1'b1);
            wr_data = out_of_order ? cand : held_ff;
            held_in = out_of_order ? held_ff : cand;
            if (out_of_order) begin
               swapped_in = 1'b1;
            end
            rd_addr = AW'(idx_ff + 1'b1);
            if (idx_ff != last_idx) begin
               idx_in = AW'(idx_ff + 1'b1);
            end
         end
         bswd_pkg::ST_PASS_END: begin
            wr_en   = 1'b1;
            wr_addr = last_idx;
            wr_data = held_ff;
            idx_in  = '0;
         end
         bswd_pkg::ST_EMIT_READ: begin
            rd_addr = idx_ff;
         end
         bswd_pkg::ST_EMIT_SHOW: begin
            rd_addr = idx_ff;
            if (rsp_beat) begin
               if (rsp_tlast) begin
                  count_in = '0;
                  idx_in   = '0;
               end else begin
                  idx_in = AW'(idx_ff + 1'b1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bswd_pkg::ST_LOAD;
         count_ff   <= '0;
         idx_ff     <= '0;
         swapped_ff <= 1'b0;
         dir_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         swapped_ff <= swapped_in;
         dir_ff     <= dir_in;
      end
      held_ff <= held_in;
   end

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while results pending");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_tlast) |=> (req_tready && count_ff == '0))
      else $error("block did not return to loading after last result");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bswd_pkg::ST_PASS_RUN) |-> (idx_ff <= last_idx && count_ff >= CW'(2)))
      else $error("compare index ran past the set");

   a_stable_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while stalled");

endmodule

`default_nettype wire
